>>> design/rca_pkg.sv
// Shared types and codes for the receive credit accounting block.
package rca_pkg;

    // Operation codes carried in the input item's tuser.
    typedef enum logic [2:0] {
        OP_ACCUMULATE = 3'd0,
        OP_ROLLBACK   = 3'd1,
        OP_PAUSED_ACC = 3'd2,
        OP_RETURN     = 3'd3,
        OP_ATTACH     = 3'd4
    } rca_opcode_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK              = 3'd0,
        STAT_UNCRED_OVF      = 3'd1,
        STAT_ROLLBACK_UNF    = 3'd2,
        STAT_PAUSED_OVF      = 3'd3,
        STAT_PAUSED_EXCEEDS  = 3'd4,
        STAT_RETURN_FAIL     = 3'd5
    } rca_status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_CHUNK = 2'd2
    } rca_state_t;

    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned AMOUNT_W = 22;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CREDIT_W = 16;
    localparam int unsigned MAX_CHUNKS = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the input item
        logic exec;        // evaluate the operation and update the counts
        logic emit_chunk;  // load the next window-update chunk
    } rca_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;      // output register can take a new item
        logic start_chunks;  // the operation under evaluation is a nonzero return
        logic last_chunk;    // the remaining amount fits in one chunk
    } rca_stat_t;

endpackage

>>> design/rca_ctrl.sv
// Controller state machine for the receive credit accounting block.
module rca_ctrl
    import rca_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rca_stat_t dp_stat,
    output rca_cmd_t  cmd
);

    rca_state_t state_reg;
    rca_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (dp_stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = dp_stat.start_chunks ? S_CHUNK : S_IDLE;
                end
            end
            S_CHUNK: begin
                if (dp_stat.out_free) begin
                    cmd.emit_chunk = 1'b1;
                    if (dp_stat.last_chunk) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/rca_dp.sv
// Datapath: counts, flow flags, chunk counter and the output register.
module rca_dp
    import rca_pkg::*;
#(
    parameter int unsigned CHUNK_MAX = 65535
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic [OPCODE_W-1:0] in_opcode,
    input  logic [AMOUNT_W-1:0] in_amount,
    input  rca_cmd_t            cmd,
    output rca_stat_t           dp_stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tlast
);

    localparam logic [AMOUNT_W-1:0] CHUNK_A = AMOUNT_W'(CHUNK_MAX);
    localparam logic [AMOUNT_W-1:0] CAP_A   = AMOUNT_W'(MAX_CHUNKS * CHUNK_MAX);

    logic                is_tcp_reg;
    logic                attached_reg;
    logic [COUNT_W-1:0]  unc_reg;
    logic [COUNT_W-1:0]  paused_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [AMOUNT_W-1:0] rem_reg;

    logic                ovalid_reg;
    logic [2:0]          ostatus_reg;
    logic                oabort_reg;
    logic                oclose_reg;
    logic [CREDIT_W-1:0] ocredit_reg;
    logic                olast_reg;

    logic [COUNT_W:0]    sum_unc;
    logic [COUNT_W:0]    sum_paused;
    logic [COUNT_W-1:0]  amt_ext;
    logic [AMOUNT_W-1:0] amt_sat;
    logic [COUNT_W-1:0]  amt_sat_ext;
    logic                fail;
    rca_status_t         fail_code;
    logic                go_chunks;
    logic [AMOUNT_W-1:0] chunk;
    logic                out_free;

    // Flow-kind register; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_tcp_reg <= 1'b1;
        end else if (cfg_valid) begin
            is_tcp_reg <= cfg_data;
        end
    end

    // Input capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= in_opcode;
            amt_reg <= in_amount;
        end
    end

    // Checks of the captured operation against the counts.
    always_comb begin
        amt_ext     = COUNT_W'(amt_reg);
        sum_unc     = {1'b0, unc_reg} + {1'b0, amt_ext};
        sum_paused  = {1'b0, paused_reg} + {1'b0, amt_ext};
        amt_sat     = (amt_reg > CAP_A) ? CAP_A : amt_reg;
        amt_sat_ext = COUNT_W'(amt_sat);
        fail        = 1'b0;
        fail_code   = STAT_OK;
        go_chunks   = 1'b0;
        case (op_reg)
            OP_ACCUMULATE: begin
                if (!is_tcp_reg || sum_unc[COUNT_W]) begin
                    fail      = 1'b1;
                    fail_code = STAT_UNCRED_OVF;
                end
            end
            OP_ROLLBACK: begin
                if (amt_ext > unc_reg) begin
                    fail      = 1'b1;
                    fail_code = STAT_ROLLBACK_UNF;
                end
            end
            OP_PAUSED_ACC: begin
                if (!is_tcp_reg || sum_paused[COUNT_W]) begin
                    fail      = 1'b1;
                    fail_code = STAT_PAUSED_OVF;
                end else if (sum_paused[COUNT_W-1:0] > unc_reg) begin
                    fail      = 1'b1;
                    fail_code = STAT_PAUSED_EXCEEDS;
                end
            end
            OP_RETURN: begin
                if (!is_tcp_reg || !attached_reg || amt_sat_ext > unc_reg) begin
                    fail      = 1'b1;
                    fail_code = STAT_RETURN_FAIL;
                end else begin
                    go_chunks = (amt_sat != '0);
                end
            end
            default: begin
                fail = 1'b0;
            end
        endcase
    end

    // Next chunk of the credit return.
    assign chunk = (rem_reg > CHUNK_A) ? CHUNK_A : rem_reg;

    // Flow state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unc_reg      <= '0;
            paused_reg   <= '0;
            attached_reg <= 1'b0;
        end else if (cmd.exec) begin
            if (fail) begin
                unc_reg      <= '0;
                paused_reg   <= '0;
                attached_reg <= 1'b0;
            end else begin
                case (op_reg)
                    OP_ACCUMULATE: unc_reg    <= sum_unc[COUNT_W-1:0];
                    OP_ROLLBACK:   unc_reg    <= unc_reg - amt_ext;
                    OP_PAUSED_ACC: paused_reg <= sum_paused[COUNT_W-1:0];
                    OP_RETURN:     unc_reg    <= unc_reg - amt_sat_ext;
                    OP_ATTACH:     attached_reg <= 1'b1;
                    default:       attached_reg <= attached_reg;
                endcase
            end
        end
    end

    // Remaining bytes of a credit return.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rem_reg <= amt_sat;
        end else if (cmd.emit_chunk) begin
            rem_reg <= rem_reg - chunk;
        end
    end

    // Output register valid flag.
    assign out_free = !ovalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if ((cmd.exec && !go_chunks) || cmd.emit_chunk) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.exec && !go_chunks) begin
            ostatus_reg <= fail_code;
            oabort_reg  <= fail && attached_reg;
            oclose_reg  <= fail;
            ocredit_reg <= '0;
            olast_reg   <= 1'b1;
        end else if (cmd.emit_chunk) begin
            ostatus_reg <= STAT_OK;
            oabort_reg  <= 1'b0;
            oclose_reg  <= 1'b0;
            ocredit_reg <= chunk[CREDIT_W-1:0];
            olast_reg   <= (rem_reg <= CHUNK_A);
        end
    end

    assign dp_stat.out_free     = out_free;
    assign dp_stat.start_chunks = go_chunks;
    assign dp_stat.last_chunk   = (rem_reg <= CHUNK_A);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, ocredit_reg, oclose_reg, oabort_reg, ostatus_reg};
    assign m_tlast  = olast_reg;

endmodule

>>> design/receive_credit_accounting_top.sv
// Receive credit accounting: keeps the uncredited and paused byte counts of one TCP flow
// and turns credit returns into window updates of at most CHUNK_MAX bytes each. One item
// is taken at a time: it is accepted in the idle step, evaluated in the evaluate step,
// and a nonzero credit return then sends its chunks in the chunk step, one chunk per
// cycle from the single output register while the result side does not stall. A stall
// on the result side holds the block in its current step. The flow-kind register
// resets to TCP and is written through cfg_valid/cfg_data; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module receive_credit_accounting_top
    import rca_pkg::*;
#(
    parameter int unsigned CHUNK_MAX = 65535
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: is_tcp_flow.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [21:0] amount, [23:22] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [3] abort_connection,
                                   // [4] close_request, [20:5] window_credit, [23:21] zero
    output logic        m_tlast    // last
);

    rca_cmd_t  cmd;
    rca_stat_t dp_stat;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    rca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    rca_dp #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_opcode (s_tuser),
        .in_amount (s_tdata[AMOUNT_W-1:0]),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> design/rca_checker.sv
// Port-level checks for the receive credit accounting block, bound to the top level.
module rca_checker
    import rca_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A failure report is always the only item of its operation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tlast && m_tdata[20:5] == 16'd0)
        else $error("failure item not last or carries credit");

    // An abort only comes with a close request and a failure status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[4] && m_tdata[2:0] != STAT_OK)
        else $error("abort without failure");

    // Window credit only appears on successful items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:5] != 16'd0 |-> m_tdata[2:0] == STAT_OK)
        else $error("credit on failed item");

endmodule

bind receive_credit_accounting_top rca_checker u_rca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/credit_ledger_pkg.sv
`timescale 1ns / 1ps
// Scoreboard package: predicts and checks the result items of the receive credit accounting block.
package credit_ledger_pkg;
    import rca_pkg::*;

    localparam logic [31:0] CHUNK_BYTES = 32'd65535;
    localparam logic [31:0] RETURN_CAP  = MAX_CHUNKS * CHUNK_BYTES;
    localparam logic [31:0] COUNT_LIMIT = 32'hFFFF_FFFF;

    // One predicted result item, field by field.
    typedef struct {
        logic [2:0]  status;
        logic        abort_connection;
        logic        close_request;
        logic [15:0] window_credit;
        logic        last;
    } window_result_t;

    class credit_ledger;
        logic           tcp_flow;
        logic [31:0]    uncredited;
        logic [31:0]    paused;
        logic           attached;
        window_result_t expected_results[$];
        int unsigned    operations;
        int unsigned    results_checked;
        int unsigned    mismatches;

        function new();
            tcp_flow        = 1'b1;
            uncredited      = '0;
            paused          = '0;
            attached        = 1'b0;
            operations      = 0;
            results_checked = 0;
            mismatches      = 0;
        endfunction

        function void set_flow_kind(logic is_tcp);
            tcp_flow = is_tcp;
        endfunction

        function void push_result(logic [2:0] status, logic abort_conn, logic close_req,
                                  logic [15:0] credit, logic last);
            window_result_t r;
            r.status           = status;
            r.abort_connection = abort_conn;
            r.close_request    = close_req;
            r.window_credit    = credit;
            r.last             = last;
            expected_results.push_back(r);
        endfunction

        // A failed check tears the flow down and reports it in a single item.
        function void fail_flow(logic [2:0] status);
            push_result(status, attached, 1'b1, 16'd0, 1'b1);
            attached   = 1'b0;
            uncredited = '0;
            paused     = '0;
        endfunction

        // Work out the result items that one accepted operation causes.
        function void note_operation(logic [2:0] opcode, logic [21:0] amount);
            logic [31:0] amt;
            logic [31:0] remaining;
            logic [31:0] chunk;
            amt = {10'd0, amount};
            operations++;
            case (opcode)
                OP_ACCUMULATE: begin
                    if (!tcp_flow || amt > COUNT_LIMIT - uncredited) begin
                        fail_flow(STAT_UNCRED_OVF);
                    end else begin
                        uncredited += amt;
                        push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                    end
                end
                OP_ROLLBACK: begin
                    // The flow kind does not matter for a rollback.
                    if (amt > uncredited) begin
                        fail_flow(STAT_ROLLBACK_UNF);
                    end else begin
                        uncredited -= amt;
                        push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                    end
                end
                OP_PAUSED_ACC: begin
                    if (!tcp_flow || amt > COUNT_LIMIT - paused) begin
                        fail_flow(STAT_PAUSED_OVF);
                    end else if (paused + amt > uncredited) begin
                        fail_flow(STAT_PAUSED_EXCEEDS);
                    end else begin
                        paused += amt;
                        push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                    end
                end
                OP_RETURN: begin
                    // Oversized returns are saturated before any check.
                    if (amt > RETURN_CAP) begin
                        amt = RETURN_CAP;
                    end
                    if (!tcp_flow || !attached || amt > uncredited) begin
                        fail_flow(STAT_RETURN_FAIL);
                    end else begin
                        uncredited -= amt;
                        if (amt == 0) begin
                            push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                        end else begin
                            remaining = amt;
                            while (remaining != 0) begin
                                chunk = (remaining < CHUNK_BYTES) ? remaining : CHUNK_BYTES;
                                remaining -= chunk;
                                push_result(STAT_OK, 1'b0, 1'b0, chunk[15:0], remaining == 0);
                            end
                        end
                    end
                end
                OP_ATTACH: begin
                    attached = 1'b1;
                    push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                end
                default: begin
                    // Unused opcodes leave the state alone.
                    push_result(STAT_OK, 1'b0, 1'b0, 16'd0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Check one accepted result item against the oldest prediction.
        function void check_result(logic [23:0] data, logic tlast);
            window_result_t want;
            if (expected_results.size() == 0) begin
                $error("Result item with no prediction waiting: tdata=%h tlast=%b", data, tlast);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            compare_field("status", 16'(want.status), 16'(data[2:0]));
            compare_field("abort_connection", 16'(want.abort_connection), 16'(data[3]));
            compare_field("close_request", 16'(want.close_request), 16'(data[4]));
            compare_field("window_credit", want.window_credit, data[20:5]);
            compare_field("last", 16'(want.last), 16'(tlast));
        endfunction

        function void report_leftovers();
            if (expected_results.size() != 0) begin
                $error("%0d predicted result items never arrived", expected_results.size());
                mismatches += expected_results.size();
            end
        endfunction
    endclass

endpackage

>>> tb/tb_receive_credit_accounting_top.sv
`timescale 1ns / 1ps
// Testbench top: drives operations and flow-kind writes into the credit block and checks results.
module tb_receive_credit_accounting_top;
    import rca_pkg::*;
    import credit_ledger_pkg::*;

    localparam logic [2:0]  OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]  OP_RESERVED_MID   = 3'd6;
    localparam logic [2:0]  OP_RESERVED_LAST  = 3'd7;
    localparam logic [21:0] AMOUNT_MAX        = 22'h3F_FFFF;
    localparam logic        FLOW_TCP          = 1'b1;
    localparam logic        FLOW_OTHER        = 1'b0;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // When set, neither side idles.
    bit           steady = 1'b0;
    credit_ledger ledger;

    receive_credit_accounting_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Result side stalls in about a fifth of the cycles.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Every accepted result item goes to the ledger.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.check_result(m_tdata, m_tlast);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [21:0] fit_amount(logic [31:0] bytes);
        return (bytes > {10'd0, AMOUNT_MAX}) ? AMOUNT_MAX : bytes[21:0];
    endfunction

    // Offer one item, leaving valid high afterwards so back-to-back items need no toggle.
    task automatic send_item(input logic [2:0] opcode, input logic [21:0] amount);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= {2'b00, amount};
        do @(posedge aclk); while (!s_tready);
        ledger.note_operation(opcode, amount);
    endtask

    // Hold off the sender until every predicted result item has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_flow_kind(input logic is_tcp);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= is_tcp;
        do @(posedge aclk); while (!cfg_ready);
        ledger.set_flow_kind(is_tcp);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed traffic steered by the predicted counts, with some noise.
    task automatic random_operation();
        int unsigned pick;
        logic [31:0] room;
        logic [2:0]  opcode;
        logic [21:0] amount;
        pick   = $urandom_range(0, 99);
        amount = 22'($urandom_range(0, 300000));
        if (pick < 4) begin
            opcode = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
            amount = 22'($urandom);
        end else if (pick < 12 ||
                     (pick >= 62 && !ledger.attached && $urandom_range(0, 3) != 0)) begin
            opcode = OP_ATTACH;
        end else if (pick < 40) begin
            opcode = OP_ACCUMULATE;
            if ($urandom_range(0, 9) == 0) begin
                amount = 22'($urandom);
            end
        end else if (pick < 50) begin
            opcode = OP_ROLLBACK;
            if ($urandom_range(0, 6) != 0) begin
                amount = 22'($urandom_range(0, fit_amount(ledger.uncredited)));
            end
        end else if (pick < 62) begin
            opcode = OP_PAUSED_ACC;
            room = (ledger.uncredited >= ledger.paused) ? ledger.uncredited - ledger.paused : '0;
            if ($urandom_range(0, 6) != 0) begin
                amount = 22'($urandom_range(0, fit_amount(room)));
            end
        end else begin
            opcode = OP_RETURN;
            case ($urandom_range(0, 19))
                0: amount = '0;
                1: amount = 22'($urandom);
                2, 3: amount = 22'($urandom_range(0, fit_amount(ledger.uncredited)));
                default: begin
                    room = (ledger.uncredited > 32'd150000) ? 32'd150000 : ledger.uncredited;
                    amount = 22'($urandom_range(0, room));
                end
            endcase
        end
        send_item(opcode, amount);
    endtask

    initial begin
        int unsigned n;
        ledger = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_flow_kind(FLOW_TCP);

        // Directed: unused opcodes, detached returns, chunking, rollback/paused/return failures.
        send_item(OP_RESERVED_LAST, AMOUNT_MAX);
        send_item(OP_RESERVED_FIRST, 22'd0);
        send_item(OP_RESERVED_MID, 22'h15_5555);
        send_item(OP_RETURN, 22'd0);
        send_item(OP_ATTACH, 22'd0);
        send_item(OP_RETURN, 22'd0);
        send_item(OP_ACCUMULATE, AMOUNT_MAX);
        send_item(OP_RETURN, AMOUNT_MAX);
        send_item(OP_ACCUMULATE, 22'd65535);
        send_item(OP_RETURN, 22'd65598);
        send_item(OP_ROLLBACK, 22'd1);
        send_item(OP_ATTACH, 22'd0);
        send_item(OP_ACCUMULATE, 22'd1000);
        send_item(OP_PAUSED_ACC, 22'd600);
        send_item(OP_PAUSED_ACC, 22'd400);
        send_item(OP_PAUSED_ACC, 22'd1);
        send_item(OP_ACCUMULATE, 22'd5000);
        send_item(OP_ROLLBACK, 22'd5000);
        send_item(OP_ROLLBACK, 22'd0);
        send_item(OP_ATTACH, 22'd0);
        send_item(OP_ACCUMULATE, 22'd100);
        send_item(OP_RETURN, 22'd101);

        // With a non-TCP flow every credit operation fails, but rollback and attach do not.
        write_flow_kind(FLOW_OTHER);
        send_item(OP_ATTACH, 22'd0);
        send_item(OP_ACCUMULATE, 22'd1);
        send_item(OP_PAUSED_ACC, 22'd0);
        send_item(OP_ATTACH, 22'd0);
        send_item(OP_RETURN, 22'd0);
        send_item(OP_ROLLBACK, 22'd0);
        write_flow_kind(FLOW_TCP);

        // Random traffic in phases, switching the flow kind between them.
        for (n = 0; n < 160; n++) begin
            random_operation();
        end
        write_flow_kind(FLOW_OTHER);
        for (n = 0; n < 60; n++) begin
            random_operation();
        end
        write_flow_kind(FLOW_TCP);
        steady = 1'b1;
        for (n = 0; n < 150; n++) begin
            if (n == 50) begin
                steady = 1'b0;
            end
            random_operation();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        ledger.report_leftovers();
        $display("Ran %0d operations: directed cases, chunked returns and random traffic",
                 ledger.operations);
        $display("under both flow kinds, with %0d result items checked.",
                 ledger.results_checked);
        if (ledger.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> receive_credit_accounting_top.f
design/rca_pkg.sv
design/rca_ctrl.sv
design/rca_dp.sv
design/receive_credit_accounting_top.sv
design/rca_checker.sv
tb/credit_ledger_pkg.sv
tb/tb_receive_credit_accounting_top.sv
